// File: sv/mfb_pkg.sv
// Package for the max-flow block: sizes, command and register codes, and the
// command and status structs between controller and datapath. No dependencies.

package mfb_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int MAT_AW    = 2 * NODE_W;
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;

	localparam int FIELD_NODE_W = 6;
	localparam int NODE_CNT_W   = 7;
	localparam int CAP_W        = 31;
	localparam int FLOW_W       = 40;
	localparam int RES_W        = FLOW_W + 2;
	localparam int CMD_W        = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;
	localparam int IN_DATA_W    = 48;

	localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

	typedef struct packed {
		logic sweep_clr;
		logic cap_sweep;
		logic cap_set;
		logic cap_add_rd;
		logic cap_add_wr;
		logic run_start;
		logic flow_sweep;
		logic bfs_init;
		logic pop;
		logic pop_load;
		logic scan_eval;
		logic walk_start;
		logic aug_start;
		logic walk_load;
		logic walk_eval;
		logic aug_eval;
		logic total_add;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic q_nonempty;
		logic visited_t;
		logic v_is_s;
		logic v_last;
		logic degenerate;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: sv/mfb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for every matrix and list memory of the max-flow block.

module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/mfb_ctrl.sv
// Controller state machine of the max-flow block.
// Depends on mfb_pkg for the command codes and the command and status structs.

module mfb_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [mfb_pkg::CMD_W-1:0] in_cmd,
	output logic                      in_ready,
	input  mfb_pkg::dp_stat_t         stat,
	output mfb_pkg::dp_cmd_t          cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CCLR  = 4'd1;
	localparam logic [3:0] ST_ADDW  = 4'd2;
	localparam logic [3:0] ST_FCLR  = 4'd3;
	localparam logic [3:0] ST_BINIT = 4'd4;
	localparam logic [3:0] ST_POP   = 4'd5;
	localparam logic [3:0] ST_POPW  = 4'd6;
	localparam logic [3:0] ST_SADDR = 4'd7;
	localparam logic [3:0] ST_SEVAL = 4'd8;
	localparam logic [3:0] ST_WP    = 4'd9;
	localparam logic [3:0] ST_WPW   = 4'd10;
	localparam logic [3:0] ST_WADDR = 4'd11;
	localparam logic [3:0] ST_WEVAL = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	logic [3:0] state_q, state_d;
	logic       phase_q, phase_d;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (in_cmd)
						mfb_pkg::CMD_CLEAR: begin
							cmd.sweep_clr = 1'b1;
							state_d = ST_CCLR;
						end
						mfb_pkg::CMD_SET: begin
							cmd.cap_set = 1'b1;
						end
						mfb_pkg::CMD_ADD: begin
							cmd.cap_add_rd = 1'b1;
							state_d = ST_ADDW;
						end
						default: begin
							cmd.run_start = 1'b1;
							if (stat.degenerate) begin
								state_d = ST_DONE;
							end else begin
								cmd.sweep_clr = 1'b1;
								state_d = ST_FCLR;
							end
						end
					endcase
				end
			end
			ST_CCLR: begin
				cmd.cap_sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_ADDW: begin
				cmd.cap_add_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_FCLR: begin
				cmd.flow_sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_BINIT;
				end
			end
			ST_BINIT: begin
				cmd.bfs_init = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				if (stat.visited_t) begin
					cmd.walk_start = 1'b1;
					phase_d = 1'b0;
					state_d = ST_WP;
				end else if (stat.q_nonempty) begin
					cmd.pop = 1'b1;
					state_d = ST_POPW;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_POPW: begin
				cmd.pop_load = 1'b1;
				state_d = ST_SADDR;
			end
			ST_SADDR: begin
				state_d = ST_SEVAL;
			end
			ST_SEVAL: begin
				cmd.scan_eval = 1'b1;
				state_d = stat.v_last ? ST_POP : ST_SADDR;
			end
			ST_WP: begin
				if (stat.v_is_s) begin
					if (!phase_q) begin
						cmd.aug_start = 1'b1;
						phase_d = 1'b1;
					end else begin
						cmd.total_add = 1'b1;
						state_d = ST_BINIT;
					end
				end else begin
					state_d = ST_WPW;
				end
			end
			ST_WPW: begin
				cmd.walk_load = 1'b1;
				state_d = ST_WADDR;
			end
			ST_WADDR: begin
				state_d = ST_WEVAL;
			end
			ST_WEVAL: begin
				if (phase_q) begin
					cmd.aug_eval = 1'b1;
				end else begin
					cmd.walk_eval = 1'b1;
				end
				state_d = ST_WP;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CCLR;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// File: sv/mfb_dp.sv
// Datapath of the max-flow block: configuration registers, capacity and flow
// matrices, search queue, predecessor list and result register.
// Depends on mfb_pkg and mfb_ram.

module mfb_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mfb_pkg::dp_cmd_t               cmd,
	output mfb_pkg::dp_stat_t              stat,
	input  logic                           cfg_we,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [mfb_pkg::FIELD_NODE_W-1:0] in_from,
	input  logic [mfb_pkg::FIELD_NODE_W-1:0] in_to,
	input  logic [mfb_pkg::CAP_W-1:0]      in_cap,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [mfb_pkg::FLOW_W-1:0]     out_data
);

	logic [mfb_pkg::NODE_CNT_W-1:0]   node_count_q;
	logic [mfb_pkg::FIELD_NODE_W-1:0] source_q;
	logic [mfb_pkg::FIELD_NODE_W-1:0] sink_q;

	logic [mfb_pkg::MAT_AW-1:0]   sweep_q;
	logic [mfb_pkg::MAT_AW-1:0]   add_addr_q;
	logic [mfb_pkg::CAP_W-1:0]    add_val_q;
	logic                         add_ok_q;
	logic [mfb_pkg::NODE_W-1:0]   u_q, v_q;
	logic [mfb_pkg::CNT_W-1:0]    head_q, tail_q;
	logic [mfb_pkg::MAX_NODES-1:0] visited_q;
	logic [mfb_pkg::CAP_W-1:0]    bot_q;
	logic [mfb_pkg::FLOW_W-1:0]   total_q;
	logic                         out_valid_q;
	logic [mfb_pkg::FLOW_W-1:0]   out_data_q;

	logic [mfb_pkg::CNT_W-1:0]    n_eff;
	logic [mfb_pkg::NODE_W-1:0]   src, snk;
	logic [mfb_pkg::MAT_AW-1:0]   in_addr, uv_addr, vu_addr;
	logic                         in_ok;
	logic [mfb_pkg::CAP_W:0]      add_sum;
	logic [mfb_pkg::CAP_W-1:0]    add_sat;

	logic                         cap_we;
	logic [mfb_pkg::MAT_AW-1:0]   cap_waddr, cap_raddr;
	logic [mfb_pkg::CAP_W-1:0]    cap_wdata, cap_rd;
	logic                         flow_we;
	logic [mfb_pkg::MAT_AW-1:0]   flow_waddr;
	logic [mfb_pkg::FLOW_W-1:0]   flow_wdata, fa_rd, fb_rd;
	logic                         q_we;
	logic [mfb_pkg::NODE_W-1:0]   q_waddr, q_wdata, q_rd, pred_rd;

	logic signed [mfb_pkg::RES_W-1:0] resid;
	logic                         resid_pos, take;

	assign src     = mfb_pkg::NODE_W'(source_q);
	assign snk     = mfb_pkg::NODE_W'(sink_q);
	assign n_eff   = (node_count_q > mfb_pkg::MAX_NODES) ? mfb_pkg::CNT_W'(mfb_pkg::MAX_NODES)
		: mfb_pkg::CNT_W'(node_count_q);
	assign in_ok   = (in_from < mfb_pkg::MAX_NODES) && (in_to < mfb_pkg::MAX_NODES);
	assign in_addr = {mfb_pkg::NODE_W'(in_from), mfb_pkg::NODE_W'(in_to)};
	assign uv_addr = {u_q, v_q};
	assign vu_addr = {v_q, u_q};

	assign add_sum = {1'b0, cap_rd} + {1'b0, add_val_q};
	assign add_sat = add_sum[mfb_pkg::CAP_W] ? mfb_pkg::CAP_MAX : add_sum[mfb_pkg::CAP_W-1:0];

	assign cap_we    = cmd.cap_sweep || (cmd.cap_set && in_ok) || (cmd.cap_add_wr && add_ok_q);
	assign cap_waddr = cmd.cap_sweep ? sweep_q : (cmd.cap_set ? in_addr : add_addr_q);
	assign cap_wdata = cmd.cap_sweep ? '0 : (cmd.cap_set ? in_cap : add_sat);
	assign cap_raddr = cmd.cap_add_rd ? in_addr : uv_addr;

	assign flow_we    = cmd.flow_sweep || cmd.aug_eval;
	assign flow_waddr = cmd.flow_sweep ? sweep_q : uv_addr;
	assign flow_wdata = cmd.flow_sweep ? '0 : (fa_rd + mfb_pkg::FLOW_W'(bot_q));

	assign resid = $signed(mfb_pkg::RES_W'(cap_rd)) - $signed(mfb_pkg::RES_W'(fa_rd))
		+ $signed(mfb_pkg::RES_W'(fb_rd));
	assign resid_pos = !resid[mfb_pkg::RES_W-1] && (resid != '0);
	assign take = cmd.scan_eval && !visited_q[v_q] && resid_pos
		&& (tail_q < mfb_pkg::CNT_W'(mfb_pkg::MAX_NODES));

	assign q_we    = cmd.bfs_init || take;
	assign q_waddr = cmd.bfs_init ? '0 : tail_q[mfb_pkg::NODE_W-1:0];
	assign q_wdata = cmd.bfs_init ? src : v_q;

	mfb_ram #(.WIDTH(mfb_pkg::CAP_W), .DEPTH(mfb_pkg::MAT_DEPTH)) u_cap_ram (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cap_raddr), .rdata(cap_rd)
	);

	mfb_ram #(.WIDTH(mfb_pkg::FLOW_W), .DEPTH(mfb_pkg::MAT_DEPTH)) u_flow_fwd_ram (
		.clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
		.raddr(uv_addr), .rdata(fa_rd)
	);

	mfb_ram #(.WIDTH(mfb_pkg::FLOW_W), .DEPTH(mfb_pkg::MAT_DEPTH)) u_flow_rev_ram (
		.clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
		.raddr(vu_addr), .rdata(fb_rd)
	);

	mfb_ram #(.WIDTH(mfb_pkg::NODE_W), .DEPTH(mfb_pkg::MAX_NODES)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[mfb_pkg::NODE_W-1:0]), .rdata(q_rd)
	);

	mfb_ram #(.WIDTH(mfb_pkg::NODE_W), .DEPTH(mfb_pkg::MAX_NODES)) u_pred_ram (
		.clk(clk), .we(take), .waddr(v_q), .wdata(u_q),
		.raddr(v_q), .rdata(pred_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= mfb_pkg::NODE_CNT_W'(64);
			source_q     <= '0;
			sink_q       <= mfb_pkg::FIELD_NODE_W'(63);
			sweep_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			visited_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					mfb_pkg::CFG_NODE_COUNT: node_count_q <= cfg_wdata;
					mfb_pkg::CFG_SOURCE:     source_q <= mfb_pkg::FIELD_NODE_W'(cfg_wdata);
					mfb_pkg::CFG_SINK:       sink_q <= mfb_pkg::FIELD_NODE_W'(cfg_wdata);
					default: ;
				endcase
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.cap_sweep || cmd.flow_sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.bfs_init) begin
				visited_q <= mfb_pkg::MAX_NODES'(1) << src;
				head_q    <= '0;
				tail_q    <= mfb_pkg::CNT_W'(1);
			end else begin
				if (cmd.pop) begin
					head_q <= head_q + 1'b1;
				end
				if (take) begin
					visited_q[v_q] <= 1'b1;
					tail_q <= tail_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_add_rd) begin
			add_addr_q <= in_addr;
			add_val_q  <= in_cap;
			add_ok_q   <= in_ok;
		end
		if (cmd.run_start) begin
			total_q <= '0;
		end else if (cmd.total_add) begin
			total_q <= total_q + mfb_pkg::FLOW_W'(bot_q);
		end
		if (cmd.pop_load) begin
			u_q <= q_rd;
			v_q <= '0;
		end else if (cmd.scan_eval) begin
			v_q <= v_q + 1'b1;
		end else if (cmd.walk_start || cmd.aug_start) begin
			v_q <= snk;
		end else if (cmd.walk_load) begin
			u_q <= pred_rd;
		end else if (cmd.walk_eval || cmd.aug_eval) begin
			v_q <= u_q;
		end
		if (cmd.walk_start) begin
			bot_q <= mfb_pkg::CAP_MAX;
		end else if (cmd.walk_eval && (resid < $signed(mfb_pkg::RES_W'(bot_q)))) begin
			bot_q <= resid[mfb_pkg::CAP_W-1:0];
		end
		if (cmd.out_load) begin
			out_data_q <= total_q;
		end
	end

	assign stat.sweep_last = &sweep_q;
	assign stat.q_nonempty = tail_q > head_q;
	assign stat.visited_t  = visited_q[snk];
	assign stat.v_is_s     = (v_q == src);
	assign stat.v_last     = ({1'b0, v_q} == (n_eff - 1'b1));
	assign stat.degenerate = (n_eff == '0) || ({1'b0, source_q} >= n_eff)
		|| ({1'b0, sink_q} >= n_eff) || (source_q == sink_q);
	assign stat.out_busy   = out_valid_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: sv/max_flow_bfs_augmenting.sv
// Max-flow block: loads an edge capacity matrix and computes maximum flow with
// breadth-first augmenting paths. Top level; depends on mfb_pkg, mfb_ctrl, mfb_dp.
//
// A set command writes the capacity memory directly; an add command reads it,
// then makes a saturating write. A clear command, and reset itself, sweep the
// 4096-entry capacity memory one entry per cycle, so no item is taken until the
// sweep ends. Unless the node count, source or sink is degenerate, a run first
// clears the flow memory, then repeats rounds: each dequeued node scans all n
// nodes (memory read, then residual check), and a found path is walked twice
// (bottleneck, then flow update). The run time is therefore data dependent, set
// by the single-read matrix memories. The result is held in an output register;
// configuration writes are taken in any cycle and must only be made while the
// block is idle.

module max_flow_bfs_augmenting (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// from_node [5:0], to_node [11:6], capacity [42:12], zero above.
	input  logic [mfb_pkg::IN_DATA_W-1:0]   s_tdata,
	// command [1:0].
	input  logic [mfb_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// max_flow [39:0].
	output logic [mfb_pkg::FLOW_W-1:0]      m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	mfb_pkg::dp_cmd_t  cmd;
	mfb_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mfb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_cmd(s_tuser), .in_ready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	mfb_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.in_from(s_tdata[5:0]), .in_to(s_tdata[11:6]), .in_cap(s_tdata[42:12]),
		.out_ready(m_tready), .out_valid(m_tvalid), .out_data(m_tdata)
	);

	// A run request always leaves the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == mfb_pkg::CMD_RUN)) |=> !s_tready)
		else $error("run request did not leave idle");

	// A new result never overwrites one still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_tvalid)
		else $error("result loaded over a pending result");

	// A result appears only after the controller loads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result valid without a load");

endmodule
